/* hdl/sird_pkg.sv */
`default_nettype none
package sird_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_RADIX  = 16;
    localparam int TDATA_W    = ((VALUE_BITS + 7) / 8) * 8;
    localparam int DIGIT_W    = $clog2(MAX_RADIX);
    localparam int REM_W      = DIGIT_W + 1;
    localparam int RADIX_W    = 5;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int PTR_W      = $clog2(VALUE_BITS + 1);
    localparam int CHAR_W     = 8;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 64;

    localparam logic [CHAR_W-1:0]  MINUS_CHAR    = 8'h2D;
    localparam logic [RADIX_W-1:0] RADIX_RESET   = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN     = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = RADIX_W'(MAX_RADIX);
    localparam logic [63:0]        ALPHA_LO_RESET = 64'd4050765991979987505;
    localparam logic [63:0]        ALPHA_HI_RESET = 64'd28821;

    typedef enum logic [1:0] {
        REG_RADIX    = 2'd0,
        REG_ALPHA_LO = 2'd1,
        REG_ALPHA_HI = 2'd2,
        REG_NONE     = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic               done;
        logic               zero;
        logic [DIGIT_W-1:0] rem;
    } t_div_stat;

    typedef struct packed {
        logic               last;
        logic [DIGIT_W-1:0] digit;
    } t_stk_stat;

endpackage
`default_nettype wire

/* hdl/sird_div.sv */
`default_nettype none
module sird_div import sird_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire logic [RADIX_W-1:0]    i_radix,
    output t_div_stat                  o_stat,
    output logic [VALUE_BITS-1:0]      o_quot
);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [VALUE_BITS-1:0] r_quot, n_quot;
    logic [DIGIT_W-1:0]    r_rem, n_rem;
    logic [REM_W-1:0]      w_trial;
    logic [REM_W-1:0]      w_radix;
    logic                  w_ge;

    // restoring division, one quotient bit per cycle
    assign w_trial = {r_rem, r_quot[VALUE_BITS-1]};
    assign w_radix = REM_W'(i_radix);
    assign w_ge    = (w_trial >= w_radix);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quot = r_quot;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quot = i_value;
            n_rem  = '0;
        end else if (r_busy) begin
            n_quot = {r_quot[VALUE_BITS-2:0], w_ge};
            n_rem  = w_ge ? DIGIT_W'(w_trial - w_radix) : DIGIT_W'(w_trial);
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(VALUE_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_quot <= n_quot;
        r_rem  <= n_rem;
    end

    assign o_stat.done = r_done;
    assign o_stat.zero = (r_quot == '0);
    assign o_stat.rem  = r_rem;
    assign o_quot      = r_quot;

endmodule
`default_nettype wire

/* hdl/sird_stack.sv */
`default_nettype none
module sird_stack import sird_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [DIGIT_W-1:0] i_digit,
    input  wire logic               i_pop,
    output t_stk_stat               o_stat
);

    // shift-register stack, top of stack at index 0
    logic [DIGIT_W-1:0] r_stk [VALUE_BITS];
    logic [PTR_W-1:0]   r_cnt, n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_stk[0] <= i_digit;
            for (int i = 1; i < VALUE_BITS; i++) begin
                r_stk[i] <= r_stk[i-1];
            end
        end else if (i_pop) begin
            for (int i = 0; i < VALUE_BITS - 1; i++) begin
                r_stk[i] <= r_stk[i+1];
            end
        end
    end

    assign o_stat.digit = r_stk[0];
    assign o_stat.last  = (r_cnt == PTR_W'(1));

endmodule
`default_nettype wire

/* hdl/signed_int_to_radix_digits_unit.sv */
// Flow: accept the value, then one bit-serial divider run per digit, then one character at a time
// (sign, then digits, most significant first), each sent as the output takes it; one item at a time.
// The shift-and-subtract divider, one quotient bit per cycle, sets the digit time.
// Reset is synchronous, active low: control clears, registers return to radix 10 and default
// alphabet.
`default_nettype none
module signed_int_to_radix_digits_unit import sird_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [TDATA_W-1:0] i_s_tdata,   // [VALUE_BITS-1:0] value
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [CHAR_W-1:0]       o_m_tdata,   // [7:0] character
    output logic                    o_m_tlast,   // last
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    t_state                r_state, n_state;
    logic [RADIX_W-1:0]    r_radix;
    logic [63:0]           r_alpha_lo;
    logic [63:0]           r_alpha_hi;
    logic                  r_neg;
    logic                  r_ov;
    logic [CHAR_W-1:0]     r_char;
    logic                  r_last;

    t_reg_idx              w_idx;
    logic                  w_wr;
    logic [RADIX_W-1:0]    w_radix_in;
    logic                  w_in_acc;
    logic [VALUE_BITS-1:0] w_val;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_slot_free;
    logic                  w_div_start;
    logic [VALUE_BITS-1:0] w_div_value;
    logic                  w_push;
    logic                  w_pop;
    logic                  w_load_sign;
    logic [VALUE_BITS-1:0] w_quot;
    logic [127:0]          w_alpha;
    logic [CHAR_W-1:0]     w_digit_char;
    t_div_stat             w_div;
    t_stk_stat             w_stk;

    // configuration
    assign w_idx      = t_reg_idx'(paddr[4:3]);
    assign w_wr       = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign w_radix_in = pwdata[RADIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix    <= RADIX_RESET;
            r_alpha_lo <= ALPHA_LO_RESET;
            r_alpha_hi <= ALPHA_HI_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_RADIX: begin
                    if (w_radix_in < RADIX_MIN) begin
                        r_radix <= RADIX_MIN;
                    end else if (w_radix_in > RADIX_MAX) begin
                        r_radix <= RADIX_MAX;
                    end else begin
                        r_radix <= w_radix_in;
                    end
                end
                REG_ALPHA_LO: r_alpha_lo <= pwdata;
                REG_ALPHA_HI: r_alpha_hi <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_RADIX:    prdata = PDATA_W'(r_radix);
            REG_ALPHA_LO: prdata = r_alpha_lo;
            REG_ALPHA_HI: prdata = r_alpha_hi;
            default:      prdata = '0;
        endcase
    end

    // input side
    assign o_s_tready = (r_state == ST_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_val      = i_s_tdata[VALUE_BITS-1:0];
    assign w_mag      = w_val[VALUE_BITS-1] ? (~w_val + 1'b1) : w_val;

    assign w_slot_free = !r_ov || i_m_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div.done && w_div.zero) begin
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (w_slot_free) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_slot_free && w_stk.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_div_start = 1'b0;
        w_div_value = w_quot;
        w_push      = 1'b0;
        w_pop       = 1'b0;
        w_load_sign = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_div_start = w_in_acc;
                w_div_value = w_mag;
            end
            ST_DIV: begin
                w_push      = w_div.done;
                w_div_start = w_div.done && !w_div.zero;
            end
            ST_SIGN: w_load_sign = w_slot_free;
            ST_EMIT: w_pop       = w_slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (w_in_acc) begin
            r_neg <= w_val[VALUE_BITS-1];
        end
    end

    sird_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_value (w_div_value),
        .i_radix (r_radix),
        .o_stat  (w_div),
        .o_quot  (w_quot)
    );

    sird_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_digit (w_div.rem),
        .i_pop   (w_pop),
        .o_stat  (w_stk)
    );

    // output register
    assign w_alpha      = {r_alpha_hi, r_alpha_lo};
    assign w_digit_char = w_alpha[{w_stk.digit, 3'b000} +: CHAR_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load_sign || w_pop) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
        if (w_load_sign) begin
            r_char <= MINUS_CHAR;
            r_last <= 1'b0;
        end else if (w_pop) begin
            r_char <= w_digit_char;
            r_last <= w_stk.last;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_char;
    assign o_m_tlast  = r_last;

endmodule
`default_nettype wire

/* hdl/sird_chk.sv */
`default_nettype none
module sird_chk import sird_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_s_tvalid,
    input wire logic               o_s_tready,
    input wire logic               o_m_tvalid,
    input wire logic               i_m_tready,
    input wire logic [CHAR_W-1:0]  o_m_tdata,
    input wire logic               o_m_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output item dropped while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while converting");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output item changed while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("reset state wrong");

endmodule

bind signed_int_to_radix_digits_unit sird_chk u_chk (.*);
`default_nettype wire
